@@ hw/rtl/dtrsm_pkg.sv @@
package dtrsm_pkg;

  localparam int UPC_W = 4;

  localparam logic [2:0] CFG_MAX_WHEEL_RATE       = 3'd0;
  localparam logic [2:0] CFG_ACCEL_RATE           = 3'd1;
  localparam logic [2:0] CFG_DECEL_RATE           = 3'd2;
  localparam logic [2:0] CFG_EXPO_WEIGHT          = 3'd3;
  localparam logic [2:0] CFG_MAX_TURN_RATE        = 3'd4;
  localparam logic [2:0] CFG_STANDSTILL_AUTHORITY = 3'd5;

  localparam logic [14:0] RST_MAX_WHEEL_RATE       = 15'd4100;
  localparam logic [15:0] RST_ACCEL_RATE           = 16'd1024;
  localparam logic [15:0] RST_DECEL_RATE           = 16'd384;
  localparam logic [15:0] RST_EXPO_WEIGHT          = 16'd22938;
  localparam logic [14:0] RST_MAX_TURN_RATE        = 15'd1513;
  localparam logic [16:0] RST_STANDSTILL_AUTHORITY = 17'd65536;

  localparam logic [16:0] UNITY_Q16 = 17'd65536;

  // ms to Q1.15 slew step: floor(rate * ms * 16 / 125)
  localparam logic [28:0] RECIP_125  = 29'd274877906;
  localparam logic [6:0]  SLEW_DEN   = 7'd125;

  localparam logic [UPC_W-1:0] PC_STOP = 4'd13;

  typedef struct packed {
    logic [14:0] max_wheel_rate;
    logic [15:0] accel_rate;
    logic [15:0] decel_rate;
    logic [15:0] expo_weight;
    logic [14:0] max_turn_rate;
    logic [16:0] standstill_authority;
  } cfg_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RATE_MS,
    MUL_MM,
    MUL_YM,
    MUL_WM2,
    MUL_Q125,
    MUL_AHI,
    MUL_ALO,
    MUL_GATE,
    MUL_EXMTR,
    MUL_BASE,
    MUL_XG
  } mul_sel_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_X,
    WB_M2,
    WB_QE,
    WB_A,
    WB_STEP,
    WB_ACCHI,
    WB_EX,
    WB_GATE,
    WB_BASE,
    WB_TURN
  } wb_sel_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_BRSTOP,
    SEQ_EMIT_MIX,
    SEQ_EMIT_STOP
  } seq_op_t;

  typedef struct packed {
    mul_sel_t         mul;
    wb_sel_t          wb;
    logic             ramp_upd;
    seq_op_t          seq;
    logic [UPC_W-1:0] target;
  } ucw_t;

  function automatic ucw_t uc_word(input mul_sel_t mul, input wb_sel_t wb,
                                   input logic ramp_upd, input seq_op_t seq);
    ucw_t w;
    w.mul      = mul;
    w.wb       = wb;
    w.ramp_upd = ramp_upd;
    w.seq      = seq;
    w.target   = PC_STOP;
    return w;
  endfunction

  // control store: one word per step
  function automatic ucw_t dtrsm_ucode(input logic [UPC_W-1:0] pc);
    ucw_t w;
    case (pc)
      4'd0:    w = uc_word(MUL_RATE_MS, WB_NONE,  1'b0, SEQ_BRSTOP);
      4'd1:    w = uc_word(MUL_MM,      WB_X,     1'b0, SEQ_NEXT);
      4'd2:    w = uc_word(MUL_YM,      WB_M2,    1'b0, SEQ_NEXT);
      4'd3:    w = uc_word(MUL_WM2,     WB_QE,    1'b0, SEQ_NEXT);
      4'd4:    w = uc_word(MUL_Q125,    WB_A,     1'b0, SEQ_NEXT);
      4'd5:    w = uc_word(MUL_AHI,     WB_STEP,  1'b0, SEQ_NEXT);
      4'd6:    w = uc_word(MUL_ALO,     WB_ACCHI, 1'b1, SEQ_NEXT);
      4'd7:    w = uc_word(MUL_GATE,    WB_EX,    1'b0, SEQ_NEXT);
      4'd8:    w = uc_word(MUL_EXMTR,   WB_GATE,  1'b0, SEQ_NEXT);
      4'd9:    w = uc_word(MUL_BASE,    WB_X,     1'b0, SEQ_NEXT);
      4'd10:   w = uc_word(MUL_XG,      WB_BASE,  1'b0, SEQ_NEXT);
      4'd11:   w = uc_word(MUL_NONE,    WB_TURN,  1'b0, SEQ_NEXT);
      4'd12:   w = uc_word(MUL_NONE,    WB_NONE,  1'b0, SEQ_EMIT_MIX);
      default: w = uc_word(MUL_NONE,    WB_NONE,  1'b0, SEQ_EMIT_STOP);
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/dtrsm_dpath.sv @@
module dtrsm_dpath
  import dtrsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ld,
  input  logic signed [15:0] throttle_raw,
  input  logic signed [15:0] steering,
  input  logic [7:0]         elapsed_ms,
  input  logic               link_up,
  input  logic               battery_locked,
  input  cfg_t               cfg,
  input  ucw_t               uc,
  input  logic               step_en,
  output logic               stop,
  output logic [15:0]        left_mix,
  output logic [15:0]        right_mix
);

  logic signed [15:0] raw_r, steer_r, ramped_r, ramped_nxt;
  logic [7:0]         ms_r;
  logic               link_r, locked_r;

  logic [63:0] prod_r;
  logic [29:0] x_r;
  logic [30:0] m2_r;
  logic [21:0] qe_r, step_r;
  logic [46:0] a_r;
  logic [63:0] acc_r;
  logic [15:0] ex_r, base_r, turn_r;
  logic [16:0] gate_r;

  logic [15:0] m, tmag, rmag;
  logic [15:0] rate_sel;
  logic [27:0] y;
  logic [16:0] w_inv, sa_sat, sa_inv;
  logic [31:0] mul_a, mul_b;
  logic [28:0] rem;
  logic [63:0] ex_sum;
  logic [30:0] base_sum;
  logic [46:0] turn_sum;

  logic signed [22:0] diff_x, step_s, diff_c;
  logic signed [16:0] head_s;
  logic [15:0]        head_u, base_c;
  logic [16:0]        base_sg, turn_sg, left_sum, right_sum;

  assign stop = !link_r || locked_r;

  assign m     = steer_r[15] ? 16'(-steer_r) : 16'(steer_r);
  assign tmag  = ramped_r[15] ? 16'(-ramped_r) : 16'(ramped_r);
  assign rmag  = raw_r[15] ? 16'(-raw_r) : 16'(raw_r);
  assign rate_sel = (rmag < tmag) ? cfg.decel_rate : cfg.accel_rate;
  assign y     = {x_r[23:0], 4'd0};
  assign w_inv = UNITY_Q16 - {1'b0, cfg.expo_weight};
  assign sa_sat = (cfg.standstill_authority > UNITY_Q16) ? UNITY_Q16
                                                          : cfg.standstill_authority;
  assign sa_inv = UNITY_Q16 - sa_sat;

  // shared multiplier operand selection
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (uc.mul)
      MUL_RATE_MS: begin mul_a = 32'(rate_sel);       mul_b = 32'(ms_r);               end
      MUL_MM:      begin mul_a = 32'(m);              mul_b = 32'(m);                  end
      MUL_YM:      begin mul_a = 32'(y);              mul_b = 32'(RECIP_125);          end
      MUL_WM2:     begin mul_a = 32'(cfg.expo_weight); mul_b = 32'(m2_r);              end
      MUL_Q125:    begin mul_a = 32'(qe_r);           mul_b = 32'(SLEW_DEN);           end
      MUL_AHI:     begin mul_a = 32'(a_r[46:16]);     mul_b = 32'(m);                  end
      MUL_ALO:     begin mul_a = 32'(a_r[15:0]);      mul_b = 32'(m);                  end
      MUL_GATE:    begin mul_a = 32'(sa_inv);         mul_b = 32'(tmag);               end
      MUL_EXMTR:   begin mul_a = 32'(ex_r);           mul_b = 32'(cfg.max_turn_rate);  end
      MUL_BASE:    begin mul_a = 32'(tmag);           mul_b = 32'(cfg.max_wheel_rate); end
      MUL_XG:      begin mul_a = 32'(x_r);            mul_b = 32'(gate_r);             end
      default:     begin mul_a = 32'd0;               mul_b = 32'd0;                   end
    endcase
  end

  assign rem      = 29'(y) - prod_r[28:0];
  assign ex_sum   = acc_r + prod_r + (64'd1 << 45);
  assign base_sum = prod_r[30:0] + 31'd16384;
  assign turn_sum = prod_r[46:0] + (47'd1 << 30);

  // slew limiter update
  always_comb begin
    diff_x = 23'(raw_r) - 23'(ramped_r);
    step_s = $signed({1'b0, step_r});
    if (diff_x > step_s) begin
      diff_c = step_s;
    end else if (diff_x < -step_s) begin
      diff_c = -step_s;
    end else begin
      diff_c = diff_x;
    end
    ramped_nxt = 16'(23'(ramped_r) + diff_c);
  end

  // steering priority and wheel mix
  always_comb begin
    head_s  = $signed({2'b00, cfg.max_wheel_rate}) - $signed({1'b0, turn_r});
    head_u  = head_s[16] ? 16'd0 : head_s[15:0];
    base_c  = (base_r > head_u) ? head_u : base_r;
    base_sg = ramped_r[15] ? 17'(-{1'b0, base_c}) : {1'b0, base_c};
    turn_sg = steer_r[15] ? 17'(-{1'b0, turn_r}) : {1'b0, turn_r};
    left_sum  = base_sg + turn_sg;
    right_sum = base_sg - turn_sg;
  end

  assign left_mix  = left_sum[15:0];
  assign right_mix = right_sum[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramped_r <= '0;
    end else if (step_en && uc.seq == SEQ_EMIT_STOP) begin
      ramped_r <= '0;
    end else if (step_en && uc.ramp_upd) begin
      ramped_r <= ramped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      raw_r    <= throttle_raw;
      steer_r  <= steering;
      ms_r     <= elapsed_ms;
      link_r   <= link_up;
      locked_r <= battery_locked;
    end
    if (step_en) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
      case (uc.wb)
        WB_X:     x_r    <= prod_r[29:0];
        WB_M2:    m2_r   <= prod_r[30:0];
        WB_QE:    qe_r   <= prod_r[56:35];
        WB_A:     a_r    <= {w_inv, 30'd0} + prod_r[46:0];
        WB_STEP:  step_r <= qe_r + 22'(rem >= 29'(SLEW_DEN));
        WB_ACCHI: acc_r  <= {prod_r[47:0], 16'd0};
        WB_EX:    ex_r   <= ex_sum[61:46];
        WB_GATE:  gate_r <= sa_sat + prod_r[31:15];
        WB_BASE:  base_r <= base_sum[30:15];
        WB_TURN:  turn_r <= turn_sum[46:31];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/drive_throttle_ramp_steer_mixer_unit.sv @@
// Differential-drive mixer with throttle slew limiter. Each input item is one
// control tick and gives exactly one result item with the left and right
// wheel targets in ticks per second and a stop flag. A short control program
// steps one shared 32x32 multiplier through the slew step, the cubic steering
// expo, the speed-dependent authority gate and the base speed, so a driving
// item runs all 13 program steps, while a stop item (link down or battery
// lockout) runs only the first step before it branches to the stop step.
// One item is in work at a time; a new item is taken as soon as the previous
// result sits in the output register, and a stalled output holds the last step.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// must only be changed while no item is in work.
module drive_throttle_ramp_steer_mixer_unit
  import dtrsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_wdata,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_throttle_raw,
  input  logic signed [15:0] in_steering,
  input  logic [7:0]         in_elapsed_ms,
  input  logic               in_link_up,
  input  logic               in_battery_locked,

  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left_target,
  output logic signed [15:0] out_right_target,
  output logic               out_wheels_stopped
);

  cfg_t             cfg_r;
  logic [UPC_W-1:0] pc_r, pc_nxt;
  logic             busy_r, busy_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      left_r, right_r;
  logic             stopped_r;

  ucw_t        uc;
  logic        accept, emit, out_free, step_en, stop;
  logic [15:0] left_mix, right_mix;

  assign uc       = dtrsm_ucode(pc_r);
  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign emit     = (uc.seq == SEQ_EMIT_MIX) || (uc.seq == SEQ_EMIT_STOP);
  assign out_free = !out_valid_r || out_ready;
  assign step_en  = busy_r && (!emit || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_wheel_rate       <= RST_MAX_WHEEL_RATE;
      cfg_r.accel_rate           <= RST_ACCEL_RATE;
      cfg_r.decel_rate           <= RST_DECEL_RATE;
      cfg_r.expo_weight          <= RST_EXPO_WEIGHT;
      cfg_r.max_turn_rate        <= RST_MAX_TURN_RATE;
      cfg_r.standstill_authority <= RST_STANDSTILL_AUTHORITY;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_WHEEL_RATE:       cfg_r.max_wheel_rate       <= cfg_wdata[14:0];
        CFG_ACCEL_RATE:           cfg_r.accel_rate           <= cfg_wdata[15:0];
        CFG_DECEL_RATE:           cfg_r.decel_rate           <= cfg_wdata[15:0];
        CFG_EXPO_WEIGHT:          cfg_r.expo_weight          <= cfg_wdata[15:0];
        CFG_MAX_TURN_RATE:        cfg_r.max_turn_rate        <= cfg_wdata[14:0];
        CFG_STANDSTILL_AUTHORITY: cfg_r.standstill_authority <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // step counter with conditional jump
  always_comb begin
    pc_nxt        = pc_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept) begin
      pc_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (step_en) begin
      case (uc.seq)
        SEQ_NEXT:   pc_nxt = pc_r + UPC_W'(1);
        SEQ_BRSTOP: pc_nxt = stop ? uc.target : pc_r + UPC_W'(1);
        default: begin
          busy_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && emit) begin
      if (uc.seq == SEQ_EMIT_STOP) begin
        left_r    <= '0;
        right_r   <= '0;
        stopped_r <= 1'b1;
      end else begin
        left_r    <= left_mix;
        right_r   <= right_mix;
        stopped_r <= 1'b0;
      end
    end
  end

  dtrsm_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ld             (accept),
    .throttle_raw   (in_throttle_raw),
    .steering       (in_steering),
    .elapsed_ms     (in_elapsed_ms),
    .link_up        (in_link_up),
    .battery_locked (in_battery_locked),
    .cfg            (cfg_r),
    .uc             (uc),
    .step_en        (step_en),
    .stop           (stop),
    .left_mix       (left_mix),
    .right_mix      (right_mix)
  );

  assign out_valid          = out_valid_r;
  assign out_left_target    = $signed(left_r);
  assign out_right_target   = $signed(right_r);
  assign out_wheels_stopped = stopped_r;

endmodule
